/* rtl/stb_pkg.sv */
// shared types and codes of the software timer bank
`timescale 1ns / 1ps

package stb_pkg;

  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int SLOT_ID_W = 4;
  localparam int TIMEOUT_W = 32;
  localparam int NOW_W     = 48;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  // operations
  localparam cmd_t CMD_ADD  = 2'd0;
  localparam cmd_t CMD_DEL  = 2'd1;
  localparam cmd_t CMD_TICK = 2'd2;
  localparam cmd_t CMD_NONE = 2'd3;

  // result codes
  localparam status_t ST_ADDED    = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_DELETED  = 3'd2;
  localparam status_t ST_NOTFOUND = 3'd3;
  localparam status_t ST_FIRED    = 3'd4;
  localparam status_t ST_DONE     = 3'd5;

endpackage

/* rtl/software_timer_bank.sv */
// top level of the software timer bank
//
// usage
//   input channel (in_valid / in_stall) carries one command per transaction:
//   add a timer, delete a timer, or tick with the current time.
//   output channel (out_valid / out_stall) returns the results: one for add
//   and delete, one per fired slot plus a closing tick-done result for tick.
//   last marks the final result of a command.
// timing
//   one command is worked on at a time. add scans the valid bits one slot per
//   cycle. tick streams the slot entries out of the entry ram, one slot per
//   cycle while no fired result is stalled; the ram read is registered, and
//   the closing tick-done result follows the scan.
//   a new command is taken as soon as the bank is idle, even while the last
//   result still sits in the output register.
// reset
//   rst clears all valid bits and the control state; the entry ram is not
//   cleared, a slot's entry only counts once an add has set its valid bit.
// stall
//   a stalled result holds; the scan pauses until the output register frees.
`timescale 1ns / 1ps

module software_timer_bank #(
  parameter int SLOTS      = 16,
  parameter int TIME_WIDTH = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [stb_pkg::CMD_W-1:0]       cmd,
  input  logic [stb_pkg::NOW_W-1:0]       now_ms,
  input  logic [stb_pkg::TIMEOUT_W-1:0]   timeout_ms,
  input  logic                            periodic,
  input  logic [stb_pkg::SLOT_ID_W-1:0]   slot_id,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [stb_pkg::STATUS_W-1:0]    status,
  output logic [stb_pkg::SLOT_ID_W-1:0]   slot_out,
  output logic                            last
);

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = SLOT_W + 1;
  localparam int TMO_W   = stb_pkg::TIMEOUT_W;
  localparam int CMP_W   = (TIME_WIDTH > TMO_W) ? TIME_WIDTH : TMO_W;
  // entry word: {periodic, timeout, begin time}
  localparam int ENTRY_W = 1 + TMO_W + TIME_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_TICK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // control registers
  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             pend, pend_next;
  logic [SLOT_W-1:0] pidx, pidx_next;
  logic [SLOTS-1:0] valid;

  // latched command payload
  logic [TIME_WIDTH-1:0]            now_r;
  logic [TMO_W-1:0]                 tmo_r;
  logic                             per_r;
  logic [stb_pkg::SLOT_ID_W-1:0]    id_r;

  // entry ram ports
  logic               ram_we, ram_re;
  logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  // valid bit updates
  logic              set_en, clr_en;
  logic [SLOT_W-1:0] set_idx, clr_idx;

  // result emission
  logic                        emit;
  stb_pkg::status_t            emit_status;
  logic [stb_pkg::SLOT_ID_W-1:0] emit_slot;
  logic                        emit_last;
  logic                        can_go;

  // tick compare on the entry just read
  logic                  rd_per;
  logic [TMO_W-1:0]      rd_tmo;
  logic [TIME_WIDTH-1:0] rd_begin;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  fire;
  logic [SLOT_W-1:0]     cur_idx;
  logic [SLOT_W-1:0]     del_idx;
  logic                  del_hit;

  assign {rd_per, rd_tmo, rd_begin} = ram_rdata;
  assign elapsed = now_r - rd_begin;
  assign fire    = pend && valid[pidx] &&
                   (CMP_W'(elapsed) >= CMP_W'(rd_tmo));
  assign can_go  = !out_valid || !out_stall;
  assign cur_idx = idx[SLOT_W-1:0];
  assign del_idx = SLOT_W'(id_r);
  assign del_hit = (32'(id_r) < 32'(SLOTS)) && valid[del_idx];

  // one command at a time; the output register stays decoupled
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    pend_next   = pend;
    pidx_next   = pidx;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = pidx;
    ram_raddr   = cur_idx;
    ram_wdata   = {per_r, tmo_r, now_r};
    set_en      = 1'b0;
    clr_en      = 1'b0;
    set_idx     = cur_idx;
    clr_idx     = pidx;
    emit        = 1'b0;
    emit_status = stb_pkg::ST_DONE;
    emit_slot   = '0;
    emit_last   = 1'b1;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          idx_next  = '0;
          pend_next = 1'b0;
          case (cmd)
            stb_pkg::CMD_ADD:  state_next = S_ADD;
            stb_pkg::CMD_DEL:  state_next = S_DEL;
            stb_pkg::CMD_TICK: state_next = S_TICK;
            default:           state_next = S_IDLE;
          endcase
        end
      end

      // lowest free slot, one valid bit per cycle
      S_ADD: begin
        if (idx == CNT_W'(SLOTS)) begin
          if (can_go) begin
            emit        = 1'b1;
            emit_status = stb_pkg::ST_FULL;
            state_next  = S_IDLE;
          end
        end else if (!valid[cur_idx]) begin
          if (can_go) begin
            emit        = 1'b1;
            emit_status = stb_pkg::ST_ADDED;
            emit_slot   = stb_pkg::SLOT_ID_W'(cur_idx);
            ram_we      = 1'b1;
            ram_waddr   = cur_idx;
            set_en      = 1'b1;
            state_next  = S_IDLE;
          end
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end

      S_DEL: begin
        if (can_go) begin
          emit       = 1'b1;
          emit_slot  = id_r;
          state_next = S_IDLE;
          if (del_hit) begin
            emit_status = stb_pkg::ST_DELETED;
            clr_en      = 1'b1;
            clr_idx     = del_idx;
          end else begin
            emit_status = stb_pkg::ST_NOTFOUND;
          end
        end
      end

      // read slot idx while slot pidx is checked and written back
      S_TICK: begin
        if (!(fire && !can_go)) begin
          if (fire) begin
            emit        = 1'b1;
            emit_status = stb_pkg::ST_FIRED;
            emit_slot   = stb_pkg::SLOT_ID_W'(pidx);
            emit_last   = 1'b0;
            ram_we      = 1'b1;
            ram_wdata   = {rd_per, rd_tmo, now_r};
            clr_en      = !rd_per;
          end
          if (idx < CNT_W'(SLOTS)) begin
            ram_re    = 1'b1;
            pend_next = 1'b1;
            pidx_next = cur_idx;
            idx_next  = idx + CNT_W'(1);
          end else begin
            pend_next  = 1'b0;
            state_next = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (can_go) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      pend      <= 1'b0;
      pidx      <= '0;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      pend  <= pend_next;
      pidx  <= pidx_next;
      if (set_en) begin
        valid[set_idx] <= 1'b1;
      end
      if (clr_en) begin
        valid[clr_idx] <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      now_r <= TIME_WIDTH'(now_ms);
      tmo_r <= timeout_ms;
      per_r <= periodic;
      id_r  <= slot_id;
    end
    if (emit) begin
      status   <= emit_status;
      slot_out <= emit_slot;
      last     <= emit_last;
    end
  end

  stb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  // a real command leaves idle on the next cycle
  a_cmd_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd != stb_pkg::CMD_NONE) |=> (state != S_IDLE))
    else $error("accepted command did not start");

  // pending read data only exists inside a tick scan
  a_pend_in_tick: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_TICK))
    else $error("pending entry outside tick");

  // write back never collides with the read of the same entry
  a_no_collision: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("ram read and write to the same entry");

  // a fired one-shot slot is free afterwards
  a_oneshot_freed: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK && fire && can_go && !rd_per) |=> !valid[$past(pidx)])
    else $error("one-shot slot still valid after firing");
`endif

endmodule

/* rtl/stb_ram.sv */
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module stb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
